// File: design/typed_refcounted_buffer_pool_defines.svh
// assertion macros shared by the buffer pool checker
`ifndef TYPED_REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`define TYPED_REFCOUNTED_BUFFER_POOL_DEFINES_SVH

// implication checked out of reset
`define TRBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trbp assertion failed");

// next-cycle implication, also active while in reset
`define TRBP_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("trbp assertion failed");

`endif

// File: design/trbp_pkg.sv
// shared types and codes of the typed buffer pool
package trbp_pkg;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_ADDREF  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd2;
    localparam logic [1:0] ST_SATURATED  = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_out;
        logic [7:0] count_after;
        logic       returned;
    } t_result;

    typedef struct packed {
        logic fs_we;
        logic rc_we;
        logic dep_we;
    } t_upd;

endpackage

// File: design/trbp_ram.sv
// generic single-write, single-read ram with registered read data
module trbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/trbp_exec.sv
// request evaluation: result fields and state updates for one transaction
module trbp_exec #(
    parameter int SLOTS_PER_POOL = 16,
    parameter int POOL_COUNT     = 4,
    parameter int COUNT_BITS     = 8
) (
    input  logic [1:0]                   i_kind,
    input  logic [1:0]                   i_pool,
    input  logic [3:0]                   i_slot,
    input  logic [$clog2(SLOTS_PER_POOL+1)-1:0] i_depth,
    input  logic [((SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1)-1:0] i_fs_data,
    input  logic [COUNT_BITS-1:0]        i_count,
    output trbp_pkg::t_result            o_res,
    output trbp_pkg::t_upd               o_upd,
    output logic [((POOL_COUNT*SLOTS_PER_POOL > 1) ?
                   $clog2(POOL_COUNT*SLOTS_PER_POOL) : 1)-1:0] o_fs_waddr,
    output logic [((SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1)-1:0] o_fs_wdata,
    output logic [((POOL_COUNT*SLOTS_PER_POOL > 1) ?
                   $clog2(POOL_COUNT*SLOTS_PER_POOL) : 1)-1:0] o_rc_waddr,
    output logic [COUNT_BITS-1:0]        o_rc_wdata,
    output logic [$clog2(SLOTS_PER_POOL+1)-1:0] o_depth_next
);
    import trbp_pkg::*;

    localparam int TOTAL = POOL_COUNT * SLOTS_PER_POOL;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int DW    = $clog2(SLOTS_PER_POOL + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  pool_ok;
    logic                  slot_ok;
    logic [31:0]           base;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;

    assign pool_ok = 32'(i_pool) < 32'(POOL_COUNT);
    assign slot_ok = 32'(i_slot) < 32'(SLOTS_PER_POOL);
    assign base    = 32'(i_pool) * 32'(SLOTS_PER_POOL);
    assign cnt_inc = i_count + COUNT_BITS'(1);
    assign cnt_dec = i_count - COUNT_BITS'(1);

    always_comb begin
        o_res        = '{status: ST_OK, slot_out: i_slot, count_after: 8'd0, returned: 1'b0};
        o_upd        = '0;
        o_fs_waddr   = AW'(base + 32'(i_depth));
        o_fs_wdata   = SW'(i_slot);
        o_rc_waddr   = AW'(base + 32'(i_slot));
        o_rc_wdata   = cnt_inc;
        o_depth_next = i_depth;
        unique case (i_kind)
            KIND_ALLOC: begin
                if (!pool_ok || i_depth == '0) begin
                    o_res = '{status: ST_EMPTY, slot_out: 4'd0, count_after: 8'd0,
                              returned: 1'b0};
                end else begin
                    // pop the newest free slot and give it one reference
                    o_depth_next = i_depth - DW'(1);
                    o_upd.dep_we = 1'b1;
                    o_upd.rc_we  = 1'b1;
                    o_rc_waddr   = AW'(base + 32'(i_fs_data));
                    o_rc_wdata   = COUNT_BITS'(1);
                    o_res        = '{status: ST_OK, slot_out: 4'(i_fs_data),
                                     count_after: 8'd1, returned: 1'b0};
                end
            end
            KIND_RELEASE, KIND_ADDREF: begin
                if (!pool_ok || !slot_ok || i_count == '0) begin
                    o_res.status = ST_NOT_IN_USE;
                end else if (i_kind == KIND_ADDREF) begin
                    if (i_count == COUNT_MAX) begin
                        o_res.status      = ST_SATURATED;
                        o_res.count_after = 8'(COUNT_MAX);
                    end else begin
                        o_upd.rc_we       = 1'b1;
                        o_res.count_after = 8'(cnt_inc);
                    end
                end else begin
                    o_upd.rc_we       = 1'b1;
                    o_rc_wdata        = cnt_dec;
                    o_res.count_after = 8'(cnt_dec);
                    if (cnt_dec == '0) begin
                        // last reference gone: push the slot back
                        o_res.returned = 1'b1;
                        if (32'(i_depth) < 32'(SLOTS_PER_POOL)) begin
                            o_upd.fs_we  = 1'b1;
                            o_upd.dep_we = 1'b1;
                            o_depth_next = i_depth + DW'(1);
                        end
                    end
                end
            end
            default: begin
                o_res = '{status: ST_OK, slot_out: i_slot, count_after: 8'd0, returned: 1'b0};
            end
        endcase
    end

endmodule

// File: design/typed_refcounted_buffer_pool.sv
// top level of the typed reference-counted buffer pool
//
//  channel   dir  payload                                       handshake
//  s_axis    in   tuser: kind; tdata: pool, slot                tvalid/tready
//  m_axis    out  tdata: status, slot_out, count_after, returned tvalid/tready
//
// one request per cycle while the result side does not stall; a request is first
// registered while the free stack and count rams are read, then the evaluation
// stage evaluates it, writes state and loads the result register.
// reset is synchronous: stack depths and ram valid bits are set at once, no
// clearing pass. s_axis_tready drops only while the evaluation stage holds a
// request that the stalled result register cannot take.
module typed_refcounted_buffer_pool #(
    parameter int SLOTS_PER_POOL = 16,
    parameter int POOL_COUNT     = 4,
    parameter int COUNT_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pool[1:0], slot[5:2], zero[7:6]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[1:0], slot_out[5:2], count_after[13:6],
                                        // returned[14], zero[15]
);
    import trbp_pkg::*;

    localparam int TOTAL = POOL_COUNT * SLOTS_PER_POOL;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int DW    = $clog2(SLOTS_PER_POOL + 1);

    // request side
    logic [1:0]            in_kind;
    logic [1:0]            in_pool;
    logic [3:0]            in_slot;
    logic                  s_accept;
    logic                  s1_adv;
    logic [DW-1:0]         dep_s0;
    logic [31:0]           base0;
    logic [AW-1:0]         fs_raddr;
    logic [AW-1:0]         rc_raddr;
    logic                  fs_hit;
    logic                  rc_hit;

    // evaluation stage
    logic                  r_s1_vld;
    logic                  n_s1_vld;
    logic [1:0]            r_s1_kind;
    logic [1:0]            r_s1_pool;
    logic [3:0]            r_s1_slot;
    logic                  r_fs_hit;
    logic [SW-1:0]         r_fs_fwd;
    logic                  r_fs_vq;
    logic [SW-1:0]         r_fs_dflt;
    logic                  r_rc_hit;
    logic [COUNT_BITS-1:0] r_rc_fwd;
    logic                  r_rc_vq;
    logic [SW-1:0]         fs_rdata;
    logic [COUNT_BITS-1:0] rc_rdata;
    logic [SW-1:0]         fs_data;
    logic [COUNT_BITS-1:0] rc_data;
    logic [PW-1:0]         s1_pidx;

    // state
    logic [DW-1:0]         r_depth [POOL_COUNT];
    logic [TOTAL-1:0]      r_fs_vld;
    logic [TOTAL-1:0]      r_rc_vld;

    // evaluation outputs
    t_result               res;
    t_upd                  upd;
    logic [AW-1:0]         fs_waddr;
    logic [SW-1:0]         fs_wdata;
    logic [AW-1:0]         rc_waddr;
    logic [COUNT_BITS-1:0] rc_wdata;
    logic [DW-1:0]         dep_next;

    // result register
    logic                  r_out_vld;
    logic                  n_out_vld;
    t_result               r_out;

    assign in_kind  = s_axis_tuser;
    assign in_pool  = s_axis_tdata[1:0];
    assign in_slot  = s_axis_tdata[5:2];

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s1_pidx       = PW'(r_s1_pool);

    // stack depth as left by the request now being evaluated
    assign dep_s0 = (s1_adv && upd.dep_we && r_s1_pool == in_pool) ?
                    dep_next : r_depth[PW'(in_pool)];

    assign base0    = 32'(in_pool) * 32'(SLOTS_PER_POOL);
    assign fs_raddr = AW'(base0 + 32'(dep_s0) - 32'd1);
    assign rc_raddr = AW'(base0 + 32'(in_slot));
    assign fs_hit   = s1_adv && upd.fs_we && fs_waddr == fs_raddr;
    assign rc_hit   = s1_adv && upd.rc_we && rc_waddr == rc_raddr;

    assign n_s1_vld  = s_accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
    assign n_out_vld = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fs_vld  <= '0;
            r_rc_vld  <= '0;
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_depth[p] <= DW'(SLOTS_PER_POOL);
            end
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (s1_adv && upd.fs_we) begin
                r_fs_vld[fs_waddr] <= 1'b1;
            end
            if (s1_adv && upd.rc_we) begin
                r_rc_vld[rc_waddr] <= 1'b1;
            end
            if (s1_adv && upd.dep_we) begin
                r_depth[s1_pidx] <= dep_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_kind <= in_kind;
            r_s1_pool <= in_pool;
            r_s1_slot <= in_slot;
            r_fs_hit  <= fs_hit;
            r_fs_fwd  <= fs_wdata;
            r_fs_vq   <= r_fs_vld[fs_raddr];
            r_fs_dflt <= SW'(dep_s0 - DW'(1));
            r_rc_hit  <= rc_hit;
            r_rc_fwd  <= rc_wdata;
            r_rc_vq   <= r_rc_vld[rc_raddr];
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    trbp_ram #(
        .WIDTH (SW),
        .DEPTH (TOTAL)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (s1_adv && upd.fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (s_accept),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    trbp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TOTAL)
    ) u_ref_count (
        .i_clk   (i_clk),
        .i_we    (s1_adv && upd.rc_we),
        .i_waddr (rc_waddr),
        .i_wdata (rc_wdata),
        .i_re    (s_accept),
        .i_raddr (rc_raddr),
        .o_rdata (rc_rdata)
    );

    // unwritten stack entries hold their own position, unwritten counts are zero
    assign fs_data = r_fs_hit ? r_fs_fwd : (r_fs_vq ? fs_rdata : r_fs_dflt);
    assign rc_data = r_rc_hit ? r_rc_fwd : (r_rc_vq ? rc_rdata : '0);

    trbp_exec #(
        .SLOTS_PER_POOL (SLOTS_PER_POOL),
        .POOL_COUNT     (POOL_COUNT),
        .COUNT_BITS     (COUNT_BITS)
    ) u_exec (
        .i_kind       (r_s1_kind),
        .i_pool       (r_s1_pool),
        .i_slot       (r_s1_slot),
        .i_depth      (r_depth[s1_pidx]),
        .i_fs_data    (fs_data),
        .i_count      (rc_data),
        .o_res        (res),
        .o_upd        (upd),
        .o_fs_waddr   (fs_waddr),
        .o_fs_wdata   (fs_wdata),
        .o_rc_waddr   (rc_waddr),
        .o_rc_wdata   (rc_wdata),
        .o_depth_next (dep_next)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out.returned, r_out.count_after, r_out.slot_out,
                            r_out.status};

endmodule

// File: design/trbp_checker.sv
// port-level assertions for the buffer pool, bound to the top level
`include "typed_refcounted_buffer_pool_defines.svh"

module trbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic s_accept;
    logic out_stall;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // no result comes out of reset
    `TRBP_ASSERT_NXT(a_rst_idle, i_clk, !i_rst_n, !m_axis_tvalid)

    // a stalled result holds its payload
    `TRBP_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, out_stall, ##1 (m_axis_tvalid && $stable(m_axis_tdata)))

    // every taken request is followed by a valid result once it has passed the evaluation stage and the result register
    `TRBP_ASSERT_IMP(a_latency, i_clk, i_rst_n, s_accept, ##2 m_axis_tvalid)

    // with the output register empty the block always takes requests
    `TRBP_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind typed_refcounted_buffer_pool trbp_checker u_trbp_checker (.*);
